[rtl/tht_pkg.sv]
package tht_pkg;

    localparam int INDEX_BITS = 15;

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 16;
    localparam int TURN_W  = 10;
    localparam int DEPTH_W = 8;
    localparam int EXTRA_W = 32;
    localparam int COUNT_W = 32;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  move;
        logic [TURN_W-1:0]  turn;
        logic [DEPTH_W-1:0] depth;
        logic [EXTRA_W-1:0] extra;
    } t_entry;

    // bucket decision handed from the evaluator to the sequencer
    typedef struct packed {
        logic   found;
        t_entry hit;     // matched entry, zero on miss or non-lookup
        logic   wr_en;
        logic   wr_sel;  // 0: first slot, 1: second slot
    } t_eval_res;

    typedef struct packed {
        logic               found;
        logic [MOVE_W-1:0]  move;
        logic [TURN_W-1:0]  turn;
        logic [DEPTH_W-1:0] depth;
        logic [EXTRA_W-1:0] extra;
        logic [COUNT_W-1:0] access_total;
        logic [COUNT_W-1:0] hit_total;
    } t_rsp;

endpackage

[rtl/tht_ifs.sv]
interface tht_req_if;
    logic                          valid;
    logic                          ready;
    logic [tht_pkg::MODE_W-1:0]    mode;
    logic [tht_pkg::KEY_W-1:0]     key;
    logic [tht_pkg::MOVE_W-1:0]    move_in;
    logic [tht_pkg::TURN_W-1:0]    turn_in;
    logic [tht_pkg::DEPTH_W-1:0]   depth_in;
    logic [tht_pkg::EXTRA_W-1:0]   extra_in;

    modport source (
        output valid, mode, key, move_in, turn_in, depth_in, extra_in,
        input  ready
    );
    modport sink (
        input  valid, mode, key, move_in, turn_in, depth_in, extra_in,
        output ready
    );
endinterface

interface tht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [tht_pkg::MOVE_W-1:0]    move_out;
    logic [tht_pkg::TURN_W-1:0]    turn_out;
    logic [tht_pkg::DEPTH_W-1:0]   depth_out;
    logic [tht_pkg::EXTRA_W-1:0]   extra_out;
    logic [tht_pkg::COUNT_W-1:0]   access_total;
    logic [tht_pkg::COUNT_W-1:0]   hit_total;

    modport source (
        output valid, found, move_out, turn_out, depth_out, extra_out,
               access_total, hit_total,
        input  ready
    );
    modport sink (
        input  valid, found, move_out, turn_out, depth_out, extra_out,
               access_total, hit_total,
        output ready
    );
endinterface

[rtl/tht_bucket_eval.sv]
module tht_bucket_eval (
    input  logic [tht_pkg::MODE_W-1:0] i_mode,
    input  tht_pkg::t_entry            i_new,
    input  tht_pkg::t_entry            i_slot0,
    input  tht_pkg::t_entry            i_slot1,
    output tht_pkg::t_eval_res         o_res
);

    logic hit0;
    logic hit1;
    logic empty0;
    logic empty1;
    logic above0;
    logic above1;

    assign hit0   = (i_slot0.key == i_new.key);
    assign hit1   = (i_slot1.key == i_new.key);
    assign empty0 = (i_slot0.move == '0);
    assign empty1 = (i_slot1.move == '0);

    // rank by turn, depth breaks a tie
    assign above0 = (i_new.turn == i_slot0.turn) ? (i_new.depth > i_slot0.depth)
                                                 : (i_new.turn > i_slot0.turn);
    assign above1 = (i_new.turn == i_slot1.turn) ? (i_new.depth > i_slot1.depth)
                                                 : (i_new.turn > i_slot1.turn);

    always_comb begin
        o_res = '0;
        if (i_mode == tht_pkg::MODE_LOOKUP) begin
            if (hit0) begin
                o_res.found = 1'b1;
                o_res.hit   = i_slot0;
            end else if (hit1) begin
                o_res.found = 1'b1;
                o_res.hit   = i_slot1;
            end
        end else if (i_mode == tht_pkg::MODE_STORE) begin
            if (empty0) begin
                o_res.wr_en = 1'b1;
            end else if (empty1) begin
                o_res.wr_en  = 1'b1;
                o_res.wr_sel = 1'b1;
            end else if (above0) begin
                o_res.wr_en = 1'b1;
            end else if (above1) begin
                o_res.wr_en  = 1'b1;
                o_res.wr_sel = 1'b1;
            end
        end
    end

endmodule

[rtl/two_slot_hash_table_cache.sv]
// Two-way bucketed entry store keyed by a 64-bit hash. The bucket is slot
// key[INDEX_BITS-1:0] and the slot after it (wrapping at the table end).
// Mode 0 looks up both slots for an exact key match and counts accesses and
// hits; mode 1 stores into the first empty slot (move 0 = empty), else over
// the first slot that ranks below the new entry by turn then depth; mode 2
// clears both counters; mode 3 does nothing. Every item yields one result
// carrying both counter totals after the item. The table sits in a single
// memory with one read and one write port, so the two slots of a bucket are
// read one after the other: accepting an item reads the first slot, the
// ST_RD1 step reads the second, and the ST_EVAL step decides, writes back
// and loads the result into the output register. The block is ready again
// once the decide step completes, so it takes no new item while one is in
// flight. The next item is taken while a result waits, but that item holds
// in its decide step until the output register is free. After reset the
// table is swept to zero, one entry per cycle, through all 2^INDEX_BITS
// entries (32768 at the default) before the first item is accepted.
module two_slot_hash_table_cache #(
    parameter int INDEX_BITS = tht_pkg::INDEX_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tht_req_if.sink    i_req,
    tht_rsp_if.source  o_rsp
);

    localparam int DEPTH = 1 << INDEX_BITS;

    // sequencer states
    localparam logic [1:0] ST_CLR  = 2'd0;  // clearing sweep after reset
    localparam logic [1:0] ST_IDLE = 2'd1;  // ready; accept reads slot 0
    localparam logic [1:0] ST_RD1  = 2'd2;  // read slot 1, capture slot 0
    localparam logic [1:0] ST_EVAL = 2'd3;  // decide, write back, load result

    // entry memory
    tht_pkg::t_entry r_mem [DEPTH];
    tht_pkg::t_entry r_rd_data;
    logic                  mem_rd_en;
    logic [INDEX_BITS-1:0] mem_rd_addr;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_wr_addr;
    tht_pkg::t_entry       mem_wr_data;

    logic [1:0]                    r_state, n_state;
    logic [INDEX_BITS-1:0]         r_clr_idx, n_clr_idx;
    logic [tht_pkg::MODE_W-1:0]    r_mode, n_mode;
    tht_pkg::t_entry               r_new, n_new;
    tht_pkg::t_entry               r_slot0, n_slot0;
    logic [tht_pkg::COUNT_W-1:0]   r_acc, n_acc;
    logic [tht_pkg::COUNT_W-1:0]   r_hit, n_hit;
    logic                          r_out_valid, n_out_valid;
    tht_pkg::t_rsp                 r_out, n_out;

    logic [INDEX_BITS-1:0] idx0;
    logic [INDEX_BITS-1:0] idx1;
    tht_pkg::t_eval_res    ev;

    assign idx0 = r_new.key[INDEX_BITS-1:0];
    assign idx1 = idx0 + 1'b1;  // wraps at the table end

    // slot 1 is in the read register while in ST_EVAL
    tht_bucket_eval u_eval (
        .i_mode  (r_mode),
        .i_new   (r_new),
        .i_slot0 (r_slot0),
        .i_slot1 (r_rd_data),
        .o_res   (ev)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_mode      = r_mode;
        n_new       = r_new;
        n_slot0     = r_slot0;
        n_acc       = r_acc;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_rd_en   = 1'b0;
        mem_rd_addr = i_req.key[INDEX_BITS-1:0];
        mem_we      = 1'b0;
        mem_wr_addr = r_clr_idx;
        mem_wr_data = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_mode      = i_req.mode;
                    n_new.key   = i_req.key;
                    n_new.move  = i_req.move_in;
                    n_new.turn  = i_req.turn_in;
                    n_new.depth = i_req.depth_in;
                    n_new.extra = i_req.extra_in;
                    mem_rd_en   = 1'b1;
                    n_state     = ST_RD1;
                end
            end
            ST_RD1: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx1;
                n_slot0     = r_rd_data;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                // wait until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    if (r_mode == tht_pkg::MODE_LOOKUP) begin
                        n_acc = r_acc + 1'b1;
                        if (ev.found) begin
                            n_hit = r_hit + 1'b1;
                        end
                    end else if (r_mode == tht_pkg::MODE_CLEAR) begin
                        n_acc = '0;
                        n_hit = '0;
                    end
                    mem_we             = ev.wr_en;
                    mem_wr_addr        = ev.wr_sel ? idx1 : idx0;
                    mem_wr_data        = r_new;
                    n_out.found        = ev.found;
                    n_out.move         = ev.hit.move;
                    n_out.turn         = ev.hit.turn;
                    n_out.depth        = ev.hit.depth;
                    n_out.extra        = ev.hit.extra;
                    n_out.access_total = n_acc;
                    n_out.hit_total    = n_hit;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_idx   <= '0;
            r_acc       <= '0;
            r_hit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_acc       <= n_acc;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_new   <= n_new;
        r_slot0 <= n_slot0;
        r_out   <= n_out;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out.found;
    assign o_rsp.move_out     = r_out.move;
    assign o_rsp.turn_out     = r_out.turn;
    assign o_rsp.depth_out    = r_out.depth;
    assign o_rsp.extra_out    = r_out.extra;
    assign o_rsp.access_total = r_out.access_total;
    assign o_rsp.hit_total    = r_out.hit_total;

endmodule
